FILE: rtl/flha_pkg.sv
// shared types and codes for the free list heap allocator
`timescale 1ns / 1ps

package flha_pkg;

    localparam int ACTION_W = 2;
    localparam int REQ_W    = 21;
    localparam int ADDR_W   = 20;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 64;

    // link stores inside the block table
    localparam int LK_NP  = 0;
    localparam int LK_NN  = 1;
    localparam int LK_FP  = 2;
    localparam int LK_FN  = 3;
    localparam int LK_CNT = 4;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_REALLOC = 2'd2,
        ACT_RESET   = 2'd3
    } flha_action_t;

    typedef enum logic [1:0] {
        STS_DONE    = 2'd0,
        STS_NOFIT   = 2'd1,
        STS_BADADDR = 2'd2
    } flha_status_t;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_GROW  = 2'd1,
        K_RELOC = 2'd2
    } flha_kind_t;

    typedef enum logic [5:0] {
        ST_CLR, ST_INIT, ST_IDLE, ST_DEC, ST_SCAN, ST_LIVE,
        ST_AW_RD, ST_AW_CK,
        ST_SP_RD, ST_SP_CK, ST_SP_NEW, ST_SP_W2, ST_AL_FIN,
        ST_RA_RD, ST_RA_CK, ST_RA_NRD, ST_RA_NCK,
        ST_RL_RD, ST_RL_A, ST_RL_NRD, ST_RL_NCK, ST_RL_PCHK, ST_RL_PCK, ST_RL_PP,
        ST_AB_RD, ST_AB_RD2, ST_AB_W,
        ST_RM_RD, ST_RM_W, ST_PU1, ST_PU2,
        ST_OUT
    } flha_state_t;

    // write enables of the block table stores
    typedef struct packed {
        logic              st;
        logic              cap;
        logic              req;
        logic              fr;
        logic              us;
        logic [LK_CNT-1:0] lk;
    } flha_we_t;

endpackage

FILE: rtl/flha_table.sv
// block table: per-entry stores with independent write ports and one shared read address
`timescale 1ns / 1ps

module flha_table
    import flha_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AIW   = 10,
    parameter int IW    = 11,
    parameter int CW    = 21
) (
    input  logic             aclk,
    input  flha_we_t         we,
    input  logic [AIW-1:0]   wa_st,
    input  logic [CW-1:0]    wd_st,
    input  logic [AIW-1:0]   wa_cap,
    input  logic [CW-1:0]    wd_cap,
    input  logic [AIW-1:0]   wa_req,
    input  logic [REQ_W-1:0] wd_req,
    input  logic [AIW-1:0]   wa_fr,
    input  logic             wd_fr,
    input  logic [AIW-1:0]   wa_us,
    input  logic             wd_us,
    input  logic [AIW-1:0]   wa_lk [LK_CNT],
    input  logic [IW-1:0]    wd_lk [LK_CNT],
    input  logic [AIW-1:0]   ra,
    output logic [CW-1:0]    rd_st,
    output logic [CW-1:0]    rd_cap,
    output logic [REQ_W-1:0] rd_req,
    output logic             rd_fr,
    output logic             rd_us,
    output logic [IW-1:0]    rd_lk [LK_CNT]
);

    logic [CW-1:0]    st_mem  [DEPTH];
    logic [CW-1:0]    cap_mem [DEPTH];
    logic [REQ_W-1:0] req_mem [DEPTH];
    logic             fr_mem  [DEPTH];
    logic             us_mem  [DEPTH];

    always_ff @(posedge aclk) begin
        if (we.st) begin
            st_mem[wa_st] <= wd_st;
        end
        rd_st <= st_mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (we.cap) begin
            cap_mem[wa_cap] <= wd_cap;
        end
        rd_cap <= cap_mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (we.req) begin
            req_mem[wa_req] <= wd_req;
        end
        rd_req <= req_mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (we.fr) begin
            fr_mem[wa_fr] <= wd_fr;
        end
        rd_fr <= fr_mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (we.us) begin
            us_mem[wa_us] <= wd_us;
        end
        rd_us <= us_mem[ra];
    end

    for (genvar g = 0; g < LK_CNT; g++) begin : g_lk
        logic [IW-1:0] lk_mem [DEPTH];
        logic [IW-1:0] lk_q;

        always_ff @(posedge aclk) begin
            if (we.lk[g]) begin
                lk_mem[wa_lk[g]] <= wd_lk[g];
            end
            lk_q <= lk_mem[ra];
        end

        assign rd_lk[g] = lk_q;
    end

endmodule

FILE: rtl/free_list_heap_allocator_unit.sv
// free list heap allocator: sequencer over the block table with first fit / best fit search
`timescale 1ns / 1ps
// free list walk reads and checks each free block in turn; address lookup and spare-entry
//   search scan the table entries in order (one table read per cycle)
// one transaction at a time: the input stays closed until the result is handed off
// reset: aresetn (sync, active low) starts a clearing pass over every entry of the
//   table; the reset action runs the same pass before its result; s_tready stays low meanwhile
// ALIGN_BYTES must be a power of two

module free_list_heap_allocator_unit
    import flha_pkg::*;
#(
    parameter int ARENA_BYTES     = 1048576,
    parameter int MAX_BLOCKS      = 1024,
    parameter int HEADER_BYTES    = 56,
    parameter int ALIGN_BYTES     = 8,
    parameter int MIN_SPLIT_BYTES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // action[1:0], best_fit[2], request_bytes[23:3], address[43:24], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status[1:0], result_address[21:2], copy_from[41:22], copy_bytes[62:42], zero fill
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AIW = $clog2(MAX_BLOCKS);
    localparam int IW  = AIW + 1;
    localparam int CW  = $clog2(ARENA_BYTES + 1);
    localparam int XW  = ((CW > REQ_W) ? CW : REQ_W) + 3;

    localparam logic [IW-1:0]  NIL       = IW'(MAX_BLOCKS);
    localparam logic [AIW-1:0] LAST_IDX  = AIW'(MAX_BLOCKS - 1);
    localparam logic [XW-1:0]  HDR       = XW'(HEADER_BYTES);
    localparam logic [XW-1:0]  SPLIT_MIN = XW'(HEADER_BYTES + MIN_SPLIT_BYTES);
    localparam logic [XW-1:0]  AMASK     = XW'(ALIGN_BYTES - 1);
    localparam logic [CW-1:0]  INIT_CAP  = CW'(ARENA_BYTES - HEADER_BYTES);

    // sequencer and return points of the shared list / merge steps
    flha_state_t state_reg, state_next;
    flha_state_t ret_reg, ret_next;
    flha_state_t ab_ret_reg, ab_ret_next;
    flha_kind_t  kind_reg, kind_next;

    // latched request
    flha_action_t      act_reg, act_next;
    logic              best_reg, best_next;
    logic [REQ_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [XW-1:0]     wanted_reg, wanted_next;

    logic [IW-1:0] head_reg, head_next;

    // table scan (lookup by address or spare entry)
    logic [IW-1:0]  sc_reg, sc_next;
    logic           sv_reg, sv_next;
    logic [AIW-1:0] si_reg, si_next;
    logic           hit_reg, hit_next;
    logic           live_free_reg, live_free_next;
    logic           scan_live_reg, scan_live_next;

    // free list walk
    logic [IW-1:0] aw_b_reg, aw_b_next;
    logic [IW-1:0] ch_reg, ch_next;
    logic [CW-1:0] ch_cap_reg, ch_cap_next;
    logic [CW-1:0] ch_st_reg, ch_st_next;
    logic          use_best_reg, use_best_next;

    // split, release, merge and reallocate operands
    logic [AIW-1:0]   tgt_reg, tgt_next;
    logic [AIW-1:0]   b_reg, b_next;
    logic [AIW-1:0]   lx_reg, lx_next;
    logic [XW-1:0]    rest_reg, rest_next;
    logic [CW-1:0]    sp_nst_reg, sp_nst_next;
    logic [IW-1:0]    sp_nn_reg, sp_nn_next;
    logic [AIW-1:0]   rel_reg, rel_next;
    logic [IW-1:0]    rl_n_reg, rl_n_next;
    logic [IW-1:0]    rl_p_reg, rl_p_next;
    logic [AIW-1:0]   ab_i_reg, ab_i_next;
    logic [AIW-1:0]   ab_n_reg, ab_n_next;
    logic [CW-1:0]    ab_cap_reg, ab_cap_next;
    logic [CW-1:0]    cap_b_reg, cap_b_next;
    logic [REQ_W-1:0] old_req_reg, old_req_next;
    logic [IW-1:0]    ra_n_reg, ra_n_next;

    logic [AIW-1:0] clr_reg, clr_next;
    logic           from_cmd_reg, from_cmd_next;

    // result being built, then the output register
    flha_status_t      status_reg, status_next;
    logic [ADDR_W-1:0] res_reg, res_next;
    logic [ADDR_W-1:0] cf_reg, cf_next;
    logic [REQ_W-1:0]  cb_reg, cb_next;
    logic              m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    // table ports
    flha_we_t         we;
    logic [AIW-1:0]   wa_st, wa_cap, wa_req, wa_fr, wa_us, ra;
    logic [CW-1:0]    wd_st, wd_cap;
    logic [REQ_W-1:0] wd_req;
    logic             wd_fr, wd_us;
    logic [AIW-1:0]   wa_lk [LK_CNT];
    logic [IW-1:0]    wd_lk [LK_CNT];
    logic [CW-1:0]    r_st, r_cap;
    logic [REQ_W-1:0] r_req;
    logic             r_fr, r_us;
    logic [IW-1:0]    r_lk [LK_CNT];

    // shared compare / add datapath terms
    logic          scan_match;
    logic [XW-1:0] rest_calc;

    flha_table #(
        .DEPTH (MAX_BLOCKS),
        .AIW   (AIW),
        .IW    (IW),
        .CW    (CW)
    ) u_table (
        .aclk   (aclk),
        .we     (we),
        .wa_st  (wa_st),
        .wd_st  (wd_st),
        .wa_cap (wa_cap),
        .wd_cap (wd_cap),
        .wa_req (wa_req),
        .wd_req (wd_req),
        .wa_fr  (wa_fr),
        .wd_fr  (wd_fr),
        .wa_us  (wa_us),
        .wd_us  (wd_us),
        .wa_lk  (wa_lk),
        .wd_lk  (wd_lk),
        .ra     (ra),
        .rd_st  (r_st),
        .rd_cap (r_cap),
        .rd_req (r_req),
        .rd_fr  (r_fr),
        .rd_us  (r_us),
        .rd_lk  (r_lk)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // live lookup hits a used entry whose payload offset is the address; spare search hits
    // the first unused entry
    assign scan_match = scan_live_reg ?
                        (r_us && ((XW'(r_st) + HDR) == XW'(ptr_reg))) : !r_us;
    assign rest_calc  = XW'(r_cap) - wanted_reg;

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        ab_ret_next    = ab_ret_reg;
        kind_next      = kind_reg;
        act_next       = act_reg;
        best_next      = best_reg;
        size_next      = size_reg;
        ptr_next       = ptr_reg;
        wanted_next    = wanted_reg;
        head_next      = head_reg;
        sc_next        = sc_reg;
        sv_next        = sv_reg;
        si_next        = si_reg;
        hit_next       = hit_reg;
        live_free_next = live_free_reg;
        scan_live_next = scan_live_reg;
        aw_b_next      = aw_b_reg;
        ch_next        = ch_reg;
        ch_cap_next    = ch_cap_reg;
        ch_st_next     = ch_st_reg;
        use_best_next  = use_best_reg;
        tgt_next       = tgt_reg;
        b_next         = b_reg;
        lx_next        = lx_reg;
        rest_next      = rest_reg;
        sp_nst_next    = sp_nst_reg;
        sp_nn_next     = sp_nn_reg;
        rel_next       = rel_reg;
        rl_n_next      = rl_n_reg;
        rl_p_next      = rl_p_reg;
        ab_i_next      = ab_i_reg;
        ab_n_next      = ab_n_reg;
        ab_cap_next    = ab_cap_reg;
        cap_b_next     = cap_b_reg;
        old_req_next   = old_req_reg;
        ra_n_next      = ra_n_reg;
        clr_next       = clr_reg;
        from_cmd_next  = from_cmd_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        cf_next        = cf_reg;
        cb_next        = cb_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        we     = '0;
        wa_st  = '0;
        wd_st  = '0;
        wa_cap = '0;
        wd_cap = '0;
        wa_req = '0;
        wd_req = '0;
        wa_fr  = '0;
        wd_fr  = 1'b0;
        wa_us  = '0;
        wd_us  = 1'b0;
        ra     = '0;
        for (int i = 0; i < LK_CNT; i++) begin
            wa_lk[i] = '0;
            wd_lk[i] = '0;
        end

        // output register drains independently of the sequencer
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // clearing pass: mark every entry unused
            ST_CLR: begin
                we.us    = 1'b1;
                wa_us    = clr_reg;
                wd_us    = 1'b0;
                clr_next = clr_reg + AIW'(1);
                if (clr_reg == LAST_IDX) begin
                    state_next = ST_INIT;
                end
            end

            // entry 0 becomes the single free block
            ST_INIT: begin
                we.st  = 1'b1;
                wd_st  = '0;
                we.cap = 1'b1;
                wd_cap = INIT_CAP;
                we.fr  = 1'b1;
                wd_fr  = 1'b1;
                we.us  = 1'b1;
                wd_us  = 1'b1;
                we.lk  = '1;
                for (int i = 0; i < LK_CNT; i++) begin
                    wd_lk[i] = NIL;
                end
                head_next     = '0;
                from_cmd_next = 1'b0;
                state_next    = from_cmd_reg ? ST_OUT : ST_IDLE;
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next    = flha_action_t'(s_tdata[1:0]);
                    best_next   = s_tdata[2];
                    size_next   = s_tdata[23:3];
                    ptr_next    = s_tdata[43:24];
                    wanted_next = (XW'(s_tdata[23:3]) + AMASK) & ~AMASK;
                    status_next = STS_DONE;
                    res_next    = '0;
                    cf_next     = '0;
                    cb_next     = '0;
                    state_next  = ST_DEC;
                end
            end

            ST_DEC: begin
                case (act_reg)
                    ACT_ALLOC, ACT_REALLOC: begin
                        if (act_reg == ACT_REALLOC && ptr_reg != '0) begin
                            sc_next        = '0;
                            sv_next        = 1'b0;
                            scan_live_next = 1'b1;
                            state_next     = ST_SCAN;
                        end else if (size_reg == '0) begin
                            status_next = STS_NOFIT;
                            state_next  = ST_OUT;
                        end else begin
                            kind_next     = K_ALLOC;
                            use_best_next = (act_reg == ACT_ALLOC) && best_reg;
                            aw_b_next     = head_reg;
                            ch_next       = NIL;
                            state_next    = ST_AW_RD;
                        end
                    end
                    ACT_FREE: begin
                        if (ptr_reg == '0) begin
                            state_next = ST_OUT;
                        end else begin
                            sc_next        = '0;
                            sv_next        = 1'b0;
                            scan_live_next = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default: begin
                        clr_next      = '0;
                        from_cmd_next = 1'b1;
                        state_next    = ST_CLR;
                    end
                endcase
            end

            // one table read issued per cycle, the previous one checked
            ST_SCAN: begin
                if (sv_reg && scan_match) begin
                    hit_next       = 1'b1;
                    live_free_next = r_fr;
                    state_next     = scan_live_reg ? ST_LIVE : ST_SP_NEW;
                end else if (sc_reg == NIL) begin
                    hit_next   = 1'b0;
                    state_next = scan_live_reg ? ST_LIVE : ST_SP_NEW;
                end else begin
                    ra      = sc_reg[AIW-1:0];
                    si_next = sc_reg[AIW-1:0];
                    sv_next = 1'b1;
                    sc_next = sc_reg + IW'(1);
                end
            end

            ST_LIVE: begin
                if (!hit_reg || live_free_reg) begin
                    status_next = STS_BADADDR;
                    state_next  = ST_OUT;
                end else begin
                    b_next = si_reg;
                    if (act_reg == ACT_FREE || size_reg == '0) begin
                        rel_next   = si_reg;
                        state_next = ST_RL_RD;
                    end else begin
                        state_next = ST_RA_RD;
                    end
                end
            end

            // free list walk, first fit or best fit
            ST_AW_RD: begin
                if (aw_b_reg < NIL) begin
                    ra         = aw_b_reg[AIW-1:0];
                    state_next = ST_AW_CK;
                end else if (ch_reg == NIL) begin
                    status_next = STS_NOFIT;
                    state_next  = ST_OUT;
                end else begin
                    lx_next    = ch_reg[AIW-1:0];
                    tgt_next   = ch_reg[AIW-1:0];
                    ret_next   = ST_SP_RD;
                    state_next = ST_RM_RD;
                end
            end

            ST_AW_CK: begin
                if ((XW'(r_cap) >= wanted_reg) &&
                    (ch_reg == NIL || (use_best_reg && r_cap < ch_cap_reg))) begin
                    ch_next     = aw_b_reg;
                    ch_cap_next = r_cap;
                    ch_st_next  = r_st;
                end
                aw_b_next  = r_lk[LK_FN];
                state_next = ST_AW_RD;
            end

            // split the target when the rest holds a header plus the minimum payload
            ST_SP_RD: begin
                ra         = tgt_reg;
                state_next = ST_SP_CK;
            end

            ST_SP_CK: begin
                if (rest_calc < SPLIT_MIN) begin
                    state_next = ST_AL_FIN;
                end else begin
                    rest_next      = rest_calc;
                    sp_nst_next    = CW'(XW'(r_st) + HDR + wanted_reg);
                    sp_nn_next     = r_lk[LK_NN];
                    sc_next        = '0;
                    sv_next        = 1'b0;
                    scan_live_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end

            ST_SP_NEW: begin
                if (!hit_reg) begin
                    // table full, no split
                    state_next = ST_AL_FIN;
                end else begin
                    we.st         = 1'b1;
                    wa_st         = si_reg;
                    wd_st         = sp_nst_reg;
                    we.cap        = 1'b1;
                    wa_cap        = si_reg;
                    wd_cap        = CW'(rest_reg - HDR);
                    we.us         = 1'b1;
                    wa_us         = si_reg;
                    wd_us         = 1'b1;
                    we.fr         = 1'b1;
                    wa_fr         = si_reg;
                    wd_fr         = 1'b1;
                    we.lk[LK_NP]  = 1'b1;
                    wa_lk[LK_NP]  = si_reg;
                    wd_lk[LK_NP]  = IW'(tgt_reg);
                    we.lk[LK_NN]  = 1'b1;
                    wa_lk[LK_NN]  = si_reg;
                    wd_lk[LK_NN]  = sp_nn_reg;
                    state_next    = ST_SP_W2;
                end
            end

            ST_SP_W2: begin
                if (sp_nn_reg < NIL) begin
                    we.lk[LK_NP] = 1'b1;
                    wa_lk[LK_NP] = sp_nn_reg[AIW-1:0];
                    wd_lk[LK_NP] = IW'(si_reg);
                end
                we.lk[LK_NN] = 1'b1;
                wa_lk[LK_NN] = tgt_reg;
                wd_lk[LK_NN] = IW'(si_reg);
                we.cap       = 1'b1;
                wa_cap       = tgt_reg;
                wd_cap       = CW'(wanted_reg);
                lx_next      = si_reg;
                ret_next     = ST_AL_FIN;
                state_next   = ST_PU1;
            end

            ST_AL_FIN: begin
                we.req = 1'b1;
                wa_req = tgt_reg;
                wd_req = size_reg;
                we.fr  = 1'b1;
                wa_fr  = tgt_reg;
                wd_fr  = 1'b0;
                case (kind_reg)
                    K_GROW: begin
                        res_next   = ptr_reg;
                        state_next = ST_OUT;
                    end
                    K_RELOC: begin
                        res_next   = ADDR_W'(XW'(ch_st_reg) + HDR);
                        cf_next    = ptr_reg;
                        cb_next    = (old_req_reg < size_reg) ? old_req_reg : size_reg;
                        rel_next   = b_reg;
                        state_next = ST_RL_RD;
                    end
                    default: begin
                        res_next   = ADDR_W'(XW'(ch_st_reg) + HDR);
                        state_next = ST_OUT;
                    end
                endcase
            end

            // reallocate: keep, grow into a free successor, or move
            ST_RA_RD: begin
                ra         = b_reg;
                state_next = ST_RA_CK;
            end

            ST_RA_CK: begin
                cap_b_next   = r_cap;
                old_req_next = r_req;
                ra_n_next    = r_lk[LK_NN];
                if (wanted_reg <= XW'(r_cap)) begin
                    we.req     = 1'b1;
                    wa_req     = b_reg;
                    wd_req     = size_reg;
                    res_next   = ptr_reg;
                    state_next = ST_OUT;
                end else if (r_lk[LK_NN] < NIL) begin
                    state_next = ST_RA_NRD;
                end else begin
                    kind_next     = K_RELOC;
                    use_best_next = 1'b0;
                    aw_b_next     = head_reg;
                    ch_next       = NIL;
                    state_next    = ST_AW_RD;
                end
            end

            ST_RA_NRD: begin
                ra         = ra_n_reg[AIW-1:0];
                state_next = ST_RA_NCK;
            end

            ST_RA_NCK: begin
                if (r_fr && (XW'(cap_b_reg) + HDR + XW'(r_cap) >= wanted_reg)) begin
                    lx_next     = ra_n_reg[AIW-1:0];
                    ret_next    = ST_AB_RD;
                    ab_i_next   = b_reg;
                    ab_n_next   = ra_n_reg[AIW-1:0];
                    ab_ret_next = ST_SP_RD;
                    tgt_next    = b_reg;
                    kind_next   = K_GROW;
                    state_next  = ST_RM_RD;
                end else begin
                    kind_next     = K_RELOC;
                    use_best_next = 1'b0;
                    aw_b_next     = head_reg;
                    ch_next       = NIL;
                    state_next    = ST_AW_RD;
                end
            end

            // release with merge of the next, then the previous neighbor
            ST_RL_RD: begin
                ra         = rel_reg;
                state_next = ST_RL_A;
            end

            ST_RL_A: begin
                rl_n_next  = r_lk[LK_NN];
                rl_p_next  = r_lk[LK_NP];
                we.fr      = 1'b1;
                wa_fr      = rel_reg;
                wd_fr      = 1'b1;
                state_next = (r_lk[LK_NN] < NIL) ? ST_RL_NRD : ST_RL_PCHK;
            end

            ST_RL_NRD: begin
                ra         = rl_n_reg[AIW-1:0];
                state_next = ST_RL_NCK;
            end

            ST_RL_NCK: begin
                if (r_fr) begin
                    lx_next     = rl_n_reg[AIW-1:0];
                    ret_next    = ST_AB_RD;
                    ab_i_next   = rel_reg;
                    ab_n_next   = rl_n_reg[AIW-1:0];
                    ab_ret_next = ST_RL_PCHK;
                    state_next  = ST_RM_RD;
                end else begin
                    state_next = ST_RL_PCHK;
                end
            end

            ST_RL_PCHK: begin
                if (rl_p_reg < NIL) begin
                    ra         = rl_p_reg[AIW-1:0];
                    state_next = ST_RL_PCK;
                end else begin
                    state_next = ST_RL_PP;
                end
            end

            ST_RL_PCK: begin
                if (r_fr) begin
                    lx_next     = rl_p_reg[AIW-1:0];
                    ret_next    = ST_AB_RD;
                    ab_i_next   = rl_p_reg[AIW-1:0];
                    ab_n_next   = rel_reg;
                    ab_ret_next = ST_RL_PP;
                    rel_next    = rl_p_reg[AIW-1:0];
                    state_next  = ST_RM_RD;
                end else begin
                    state_next = ST_RL_PP;
                end
            end

            ST_RL_PP: begin
                lx_next    = rel_reg;
                ret_next   = ST_OUT;
                state_next = ST_PU1;
            end

            // merge the address successor into ab_i
            ST_AB_RD: begin
                ra         = ab_i_reg;
                state_next = ST_AB_RD2;
            end

            ST_AB_RD2: begin
                ab_cap_next = r_cap;
                ra          = ab_n_reg;
                state_next  = ST_AB_W;
            end

            ST_AB_W: begin
                we.cap       = 1'b1;
                wa_cap       = ab_i_reg;
                wd_cap       = CW'(XW'(ab_cap_reg) + HDR + XW'(r_cap));
                we.lk[LK_NN] = 1'b1;
                wa_lk[LK_NN] = ab_i_reg;
                wd_lk[LK_NN] = r_lk[LK_NN];
                if (r_lk[LK_NN] < NIL) begin
                    we.lk[LK_NP] = 1'b1;
                    wa_lk[LK_NP] = r_lk[LK_NN][AIW-1:0];
                    wd_lk[LK_NP] = IW'(ab_i_reg);
                end
                we.us      = 1'b1;
                wa_us      = ab_n_reg;
                wd_us      = 1'b0;
                state_next = ab_ret_reg;
            end

            // unlink lx from the free list
            ST_RM_RD: begin
                ra         = lx_reg;
                state_next = ST_RM_W;
            end

            ST_RM_W: begin
                if (r_lk[LK_FP] < NIL) begin
                    we.lk[LK_FN] = 1'b1;
                    wa_lk[LK_FN] = r_lk[LK_FP][AIW-1:0];
                    wd_lk[LK_FN] = r_lk[LK_FN];
                end else begin
                    head_next = r_lk[LK_FN];
                end
                if (r_lk[LK_FN] < NIL) begin
                    we.lk[LK_FP] = 1'b1;
                    wa_lk[LK_FP] = r_lk[LK_FN][AIW-1:0];
                    wd_lk[LK_FP] = r_lk[LK_FP];
                end
                state_next = ret_reg;
            end

            // push lx at the list head
            ST_PU1: begin
                we.lk[LK_FN] = 1'b1;
                wa_lk[LK_FN] = lx_reg;
                wd_lk[LK_FN] = head_reg;
                we.lk[LK_FP] = 1'b1;
                wa_lk[LK_FP] = lx_reg;
                wd_lk[LK_FP] = NIL;
                state_next   = ST_PU2;
            end

            ST_PU2: begin
                if (head_reg < NIL) begin
                    we.lk[LK_FP] = 1'b1;
                    wa_lk[LK_FP] = head_reg[AIW-1:0];
                    wd_lk[LK_FP] = IW'(lx_reg);
                end
                head_next  = IW'(lx_reg);
                state_next = ret_reg;
            end

            // hand the result to the output register once it is free
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, cb_reg, cf_reg, res_reg, status_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_reg      <= '0;
            from_cmd_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            head_reg     <= '0;
            ret_reg      <= ST_IDLE;
            ab_ret_reg   <= ST_IDLE;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            from_cmd_reg <= from_cmd_next;
            m_valid_reg  <= m_valid_next;
            head_reg     <= head_next;
            ret_reg      <= ret_next;
            ab_ret_reg   <= ab_ret_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        act_reg       <= act_next;
        best_reg      <= best_next;
        size_reg      <= size_next;
        ptr_reg       <= ptr_next;
        wanted_reg    <= wanted_next;
        sc_reg        <= sc_next;
        sv_reg        <= sv_next;
        si_reg        <= si_next;
        hit_reg       <= hit_next;
        live_free_reg <= live_free_next;
        scan_live_reg <= scan_live_next;
        aw_b_reg      <= aw_b_next;
        ch_reg        <= ch_next;
        ch_cap_reg    <= ch_cap_next;
        ch_st_reg     <= ch_st_next;
        use_best_reg  <= use_best_next;
        tgt_reg       <= tgt_next;
        b_reg         <= b_next;
        lx_reg        <= lx_next;
        rest_reg      <= rest_next;
        sp_nst_reg    <= sp_nst_next;
        sp_nn_reg     <= sp_nn_next;
        rel_reg       <= rel_next;
        rl_n_reg      <= rl_n_next;
        rl_p_reg      <= rl_p_next;
        ab_i_reg      <= ab_i_next;
        ab_n_reg      <= ab_n_next;
        ab_cap_reg    <= ab_cap_next;
        cap_b_reg     <= cap_b_next;
        old_req_reg   <= old_req_next;
        ra_n_reg      <= ra_n_next;
        status_reg    <= status_next;
        res_reg       <= res_next;
        cf_reg        <= cf_next;
        cb_reg        <= cb_next;
        m_data_reg    <= m_data_next;
    end

`ifndef SYNTH
    // the free list head is always an entry or null
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= NIL)
        else $error("free list head out of range");

    // an accepted transaction closes the input until its result is built
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // a new result appears only from the result-hand-off step
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(state_reg == ST_OUT))
        else $error("result without hand-off");

    // copy information only comes with a done status
    a_copy_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[41:22] != '0) |-> (m_tdata[1:0] == STS_DONE))
        else $error("copy source on failed transaction");
`endif

endmodule
